@@ rtl/hermite_grid_point_evaluator_core_assert.svh @@
// Assertion macros for the Hermite grid point evaluator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef HERMITE_GRID_POINT_EVALUATOR_CORE_ASSERT_SVH
`define HERMITE_GRID_POINT_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define HGPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HGPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hgpe_pkg.sv @@
// Shared constants and types for the Hermite grid point evaluator.
// No dependencies.
package hgpe_pkg;

	localparam int GRID_SIDE_DEF = 16;
	localparam int SAMPLES_MAX   = 4096;
	localparam int SAMPLE_W      = 12;
	localparam int SCNT_W        = 13;
	localparam int DIM_W         = 5;
	localparam int T_W           = 16;
	localparam int COORD_W       = 32;
	localparam int VEC_W         = 3 * COORD_W;
	localparam int BLEND_W       = 18;
	localparam int PROD_W        = COORD_W + BLEND_W;
	localparam int ACC_W         = 52;

	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD_POINT   = 2'd0;
	localparam op_t OP_LOAD_TANGENT = 2'd1;
	localparam op_t OP_EVALUATE     = 2'd2;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_GRID_ROWS = 2'd0;
	localparam reg_idx_t REG_GRID_COLS = 2'd1;
	localparam reg_idx_t REG_SAMPLES_U = 2'd2;
	localparam reg_idx_t REG_SAMPLES_V = 2'd3;

	localparam logic [DIM_W-1:0]  GRID_ROWS_RST = 5'd4;
	localparam logic [DIM_W-1:0]  GRID_COLS_RST = 5'd4;
	localparam logic [SCNT_W-1:0] SAMPLES_U_RST = 13'd100;
	localparam logic [SCNT_W-1:0] SAMPLES_V_RST = 13'd100;

	// fields that ride along the divider stages
	typedef struct packed {
		op_t              op;
		logic             err;
		logic [3:0]       lrow;
		logic [3:0]       lcol;
		logic [VEC_W-1:0] coord;
	} side_t;

endpackage

@@ rtl/hgpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hgpe_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/hgpe_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Needs num < den * 2**QW. No dependencies.
module hgpe_div #(
	parameter int NW = 16,
	parameter int DW = 13,
	parameter int QW = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = NW + DW;

	logic [NW-1:0] rem_s [1:QW];
	logic [QW-1:0] quo_s [1:QW];

	for (genvar s = 0; s < QW; s++) begin : g_step
		localparam int SH = QW - 1 - s;
		logic [NW-1:0] r_in;
		logic [QW-1:0] q_in;
		logic [CW-1:0] trial;
		logic          take;

		if (s == 0) begin : g_first
			assign r_in = num;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[s];
			assign q_in = quo_s[s];
		end

		assign trial = CW'(den) << SH;
		assign take  = CW'(r_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1] <= take ? (r_in - trial[NW-1:0]) : r_in;
				quo_s[s+1] <= (q_in << 1) | QW'(take);
			end
		end
	end

	assign quo = quo_s[QW];
	assign rem = rem_s[QW][DW-1:0];
endmodule

@@ rtl/hermite_grid_point_evaluator_core.sv @@
// Channel   Dir  Payload
// s_*       in   tuser: operation; tdata: row, col, x, y, z, sample_u, sample_v
// m_*       out  tuser: status; tdata: x, y, z
// apb       in   grid_rows, grid_cols, samples_u, samples_v at 0x0/0x4/0x8/0xC
// One request accepted per cycle while no result is held on m_* with m_tready low; a result
// passes 27 register stages (capture, clog2(GRID_SIDE) + 16 divider stages, five blend
// stages, output register), most of them in the chained bit-per-stage dividers.
// A result held on m_* with m_tready low freezes the whole pipeline; nothing is dropped.
// Reset clears valid bits and sets config registers to their defaults; stores hold garbage until loaded.
// Depends on hgpe_pkg, hgpe_div, hgpe_ram and the assertion header.
`include "hermite_grid_point_evaluator_core_assert.svh"
module hermite_grid_point_evaluator_core #(
	parameter int GRID_SIDE = hgpe_pkg::GRID_SIDE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [3:0] grid_row, [7:4] grid_col, [39:8] coord_x, [71:40] coord_y,
	// [103:72] coord_z, [115:104] sample_u, [127:116] sample_v
	input  logic [127:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] point_x, [63:32] point_y, [95:64] point_z
	output logic [95:0]  m_tdata,
	// [0] status
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import hgpe_pkg::*;

	localparam int RW    = $clog2(GRID_SIDE);
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = SAMPLE_W + RW;
	localparam int TNW   = SCNT_W + T_W;
	localparam int DLY   = RW + T_W;
	localparam logic signed [ACC_W-1:0] ONE_Q48  = 52'sh1_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] HALF_Q32 = 52'sh0_0000_8000_0000;
	localparam logic signed [ACC_W-1:0] HALF_Q16 = 52'sh0_0000_0000_8000;

	// configuration
	logic [DIM_W-1:0]  grid_rows_q, grid_cols_q;
	logic [SCNT_W-1:0] samples_u_q, samples_v_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_ROWS_RST;
			grid_cols_q <= GRID_COLS_RST;
			samples_u_q <= SAMPLES_U_RST;
			samples_v_q <= SAMPLES_V_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_GRID_ROWS: grid_rows_q <= pwdata[DIM_W-1:0];
				REG_GRID_COLS: grid_cols_q <= pwdata[DIM_W-1:0];
				REG_SAMPLES_U: samples_u_q <= pwdata[SCNT_W-1:0];
				REG_SAMPLES_V: samples_v_q <= pwdata[SCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_GRID_ROWS: prdata = 32'(grid_rows_q);
			REG_GRID_COLS: prdata = 32'(grid_cols_q);
			REG_SAMPLES_U: prdata = 32'(samples_u_q);
			REG_SAMPLES_V: prdata = 32'(samples_v_q);
			default:       prdata = '0;
		endcase
	end

	// clamped configuration
	logic [RW-1:0]     rows_m1, cols_m1;
	logic [SCNT_W-1:0] su_c, sv_c;

	always_comb begin
		if (grid_rows_q < 5'd2) begin
			rows_m1 = RW'(1);
		end else if (int'(grid_rows_q) > GRID_SIDE) begin
			rows_m1 = RW'(GRID_SIDE - 1);
		end else begin
			rows_m1 = RW'(grid_rows_q - 5'd1);
		end
		if (grid_cols_q < 5'd2) begin
			cols_m1 = RW'(1);
		end else if (int'(grid_cols_q) > GRID_SIDE) begin
			cols_m1 = RW'(GRID_SIDE - 1);
		end else begin
			cols_m1 = RW'(grid_cols_q - 5'd1);
		end
		if (samples_u_q == '0) begin
			su_c = SCNT_W'(1);
		end else if (int'(samples_u_q) > SAMPLES_MAX) begin
			su_c = SCNT_W'(SAMPLES_MAX);
		end else begin
			su_c = samples_u_q;
		end
		if (samples_v_q == '0) begin
			sv_c = SCNT_W'(1);
		end else if (int'(samples_v_q) > SAMPLES_MAX) begin
			sv_c = SCNT_W'(SAMPLES_MAX);
		end else begin
			sv_c = samples_v_q;
		end
	end

	// pipeline advance
	logic en;
	logic out_vld_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// stage 1: capture, range check, index products
	logic [SAMPLE_W-1:0] in_su, in_sv;
	logic                vld_s1;
	side_t               side_s1;
	logic [NW-1:0]       nu_s1, nv_s1;

	assign in_su = s_tdata[115:104];
	assign in_sv = s_tdata[127:116];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.op    <= op_t'(s_tuser);
			side_s1.err   <= (SCNT_W'(in_su) >= su_c) || (SCNT_W'(in_sv) >= sv_c);
			side_s1.lrow  <= s_tdata[3:0];
			side_s1.lcol  <= s_tdata[7:4];
			side_s1.coord <= s_tdata[103:8];
			nu_s1         <= NW'(in_su) * NW'(rows_m1);
			nv_s1         <= NW'(in_sv) * NW'(cols_m1);
		end
	end

	// row and segment division
	logic [RW-1:0]     row_a, seg_a;
	logic [SCNT_W-1:0] remu_a, remv_a;

	hgpe_div #(.NW(NW), .DW(SCNT_W), .QW(RW)) u_div_row (
		.clk(clk), .en(en), .num(nu_s1), .den(su_c), .quo(row_a), .rem(remu_a)
	);

	hgpe_div #(.NW(NW), .DW(SCNT_W), .QW(RW)) u_div_seg (
		.clk(clk), .en(en), .num(nv_s1), .den(sv_c), .quo(seg_a), .rem(remv_a)
	);

	// fraction division
	logic [T_W-1:0]    t_b;
	logic [SCNT_W-1:0] remt_b;

	hgpe_div #(.NW(TNW), .DW(SCNT_W), .QW(T_W)) u_div_frac (
		.clk(clk), .en(en), .num({remv_a, {T_W{1'b0}}}), .den(sv_c),
		.quo(t_b), .rem(remt_b)
	);

	// sideband delay lines matching the dividers
	logic [DLY:1]    vld_d;
	side_t           side_d [1:DLY];
	logic [2*RW-1:0] rs_d [1:T_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d <= '0;
		end else if (en) begin
			vld_d <= {vld_d[DLY-1:1], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[1] <= side_s1;
			for (int k = 2; k <= DLY; k++) begin
				side_d[k] <= side_d[k-1];
			end
			rs_d[1] <= {row_a, seg_a};
			for (int k = 2; k <= T_W; k++) begin
				rs_d[k] <= rs_d[k-1];
			end
		end
	end

	// store access: loads write, evaluates read
	logic          vld_b;
	side_t         side_b;
	logic [RW-1:0] row_b, seg_b;
	logic [AW-1:0] addr0, addr1, waddr;
	logic          load_ok, we_pt, we_tg;
	logic [VEC_W-1:0] p0_r, p1_r, g0_r, g1_r;

	assign vld_b   = vld_d[DLY];
	assign side_b  = side_d[DLY];
	assign row_b   = rs_d[T_W][2*RW-1:RW];
	assign seg_b   = rs_d[T_W][RW-1:0];
	assign addr0   = AW'(int'(row_b) * GRID_SIDE + int'(seg_b));
	assign addr1   = addr0 + AW'(1);
	assign waddr   = AW'(int'(side_b.lrow) * GRID_SIDE + int'(side_b.lcol));
	assign load_ok = en && vld_b && (int'(side_b.lrow) < GRID_SIDE)
		&& (int'(side_b.lcol) < GRID_SIDE);
	assign we_pt   = load_ok && (side_b.op == OP_LOAD_POINT);
	assign we_tg   = load_ok && (side_b.op == OP_LOAD_TANGENT);

	hgpe_ram #(.WIDTH(VEC_W), .DEPTH(DEPTH)) u_pt0 (
		.clk(clk), .we(we_pt), .waddr(waddr), .wdata(side_b.coord),
		.re(en), .raddr(addr0), .rdata(p0_r)
	);
	hgpe_ram #(.WIDTH(VEC_W), .DEPTH(DEPTH)) u_pt1 (
		.clk(clk), .we(we_pt), .waddr(waddr), .wdata(side_b.coord),
		.re(en), .raddr(addr1), .rdata(p1_r)
	);
	hgpe_ram #(.WIDTH(VEC_W), .DEPTH(DEPTH)) u_tg0 (
		.clk(clk), .we(we_tg), .waddr(waddr), .wdata(side_b.coord),
		.re(en), .raddr(addr0), .rdata(g0_r)
	);
	hgpe_ram #(.WIDTH(VEC_W), .DEPTH(DEPTH)) u_tg1 (
		.clk(clk), .we(we_tg), .waddr(waddr), .wdata(side_b.coord),
		.re(en), .raddr(addr1), .rdata(g1_r)
	);

	// stages 2..6: blend weights, products, sums
	logic vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic ev_s2, ev_s3, ev_s4, ev_s5, ev_s6;
	logic err_s2, err_s3, err_s4, err_s5, err_s6;
	logic [T_W-1:0]   t_s2, t_s3;
	logic [2*T_W-1:0] tt_s2, tt_s3;
	logic [3*T_W-1:0] t3_s3;
	logic [VEC_W-1:0] p0_s3, p1_s3, g0_s3, g1_s3;
	logic [VEC_W-1:0] p0_s4, p1_s4, g0_s4, g1_s4;
	logic signed [BLEND_W-1:0] b_s4 [4];
	logic signed [PROD_W-1:0]  pp_s5 [3][4];
	logic signed [ACC_W-1:0]   acc_s6 [3];
	logic signed [ACC_W-1:0]   t1w, t2w, t3w, e0, e1, e2, e3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_b;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		t1w = $signed({4'b0, t_s3, 32'b0});
		t2w = $signed({4'b0, tt_s3, 16'b0});
		t3w = $signed({4'b0, t3_s3});
		e0  = (t3w <<< 1) - (t2w <<< 1) - t2w + ONE_Q48 + HALF_Q32;
		e1  = (t2w <<< 1) + t2w - (t3w <<< 1) + HALF_Q32;
		e2  = t3w - (t2w <<< 1) + t1w + HALF_Q32;
		e3  = t3w - t2w + HALF_Q32;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ev_s2  <= side_b.op == OP_EVALUATE;
			err_s2 <= side_b.err;
			t_s2   <= t_b;
			tt_s2  <= t_b * t_b;

			ev_s3  <= ev_s2;
			err_s3 <= err_s2;
			t_s3   <= t_s2;
			tt_s3  <= tt_s2;
			t3_s3  <= (3*T_W)'(tt_s2) * (3*T_W)'(t_s2);
			p0_s3  <= p0_r;
			p1_s3  <= p1_r;
			g0_s3  <= g0_r;
			g1_s3  <= g1_r;

			ev_s4   <= ev_s3;
			err_s4  <= err_s3;
			b_s4[0] <= e0[49:32];
			b_s4[1] <= e1[49:32];
			b_s4[2] <= e2[49:32];
			b_s4[3] <= e3[49:32];
			p0_s4   <= p0_s3;
			p1_s4   <= p1_s3;
			g0_s4   <= g0_s3;
			g1_s4   <= g1_s3;

			ev_s5  <= ev_s4;
			err_s5 <= err_s4;
			for (int c = 0; c < 3; c++) begin
				pp_s5[c][0] <= $signed(p0_s4[COORD_W*c +: COORD_W]) * b_s4[0];
				pp_s5[c][1] <= $signed(p1_s4[COORD_W*c +: COORD_W]) * b_s4[1];
				pp_s5[c][2] <= $signed(g0_s4[COORD_W*c +: COORD_W]) * b_s4[2];
				pp_s5[c][3] <= $signed(g1_s4[COORD_W*c +: COORD_W]) * b_s4[3];
			end

			ev_s6  <= ev_s5;
			err_s6 <= err_s5;
			for (int c = 0; c < 3; c++) begin
				acc_s6[c] <= pp_s5[c][0] + pp_s5[c][1] + pp_s5[c][2] + pp_s5[c][3]
					+ HALF_Q16;
			end
		end
	end

	// output register: round, saturate, error zeroing
	logic [VEC_W-1:0] pt_q, pt_nxt;
	logic             status_q;

	always_comb begin
		logic signed [ACC_W-17:0] v;
		pt_nxt = '0;
		for (int c = 0; c < 3; c++) begin
			v = acc_s6[c][ACC_W-1:16];
			if (err_s6) begin
				pt_nxt[COORD_W*c +: COORD_W] = '0;
			end else if (v > 36'sh0_7FFF_FFFF) begin
				pt_nxt[COORD_W*c +: COORD_W] = 32'h7FFF_FFFF;
			end else if (v < -36'sh0_8000_0000) begin
				pt_nxt[COORD_W*c +: COORD_W] = 32'h8000_0000;
			end else begin
				pt_nxt[COORD_W*c +: COORD_W] = v[COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s6 && ev_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_q     <= pt_nxt;
			status_q <= err_s6;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = pt_q;
	assign m_tuser  = status_q;

	`HGPE_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error result with nonzero point")
	`HGPE_ASSERT_NEXT(a_no_phantom, en && !(vld_s6 && ev_s6), !m_tvalid, "result without evaluate request")
	`HGPE_ASSERT_NOW(a_cell_bound, vld_b && side_b.op == OP_EVALUATE && !side_b.err, row_b < rows_m1 && seg_b < cols_m1, "grid cell outside configured grid")
endmodule

@@ verif/hermite_grid_point_evaluator_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for hermite_grid_point_evaluator_core: loads the point and tangent stores,
// evaluates samples under several grid settings and idle patterns, and checks every result.
// Depends on hgpe_pkg and the core RTL.
module hermite_grid_point_evaluator_core_tb;
	import hgpe_pkg::*;

	typedef struct {
		logic [31:0] x, y, z;
		logic        status;
	} point_res_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [95:0]  m_tdata;
	logic         m_tuser;
	logic         psel, penable, pwrite, pready;
	logic [3:0]   paddr;
	logic [31:0]  pwdata, prdata;

	point_res_t         point_q[$];
	logic signed [31:0] pt_mem[256][3];
	logic signed [31:0] tg_mem[256][3];
	logic [4:0]         rows_reg, cols_reg;
	logic [12:0]        su_reg, sv_reg;
	int                 fail_cnt = 0;
	int                 send_idle = 0, recv_stall = 0;

	hermite_grid_point_evaluator_core uut (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall);

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic point_res_t eval_point(logic [11:0] i, logic [11:0] j);
		point_res_t r;
		longint ii, jj;
		longint rows, cols, su, sv, row, prod, seg, rem, t, t1, t2, t3, one, acc, v;
		longint b[4];
		int a0, a1;
		r = '{x: 0, y: 0, z: 0, status: 1'b0};
		ii = longint'(i);
		jj = longint'(j);
		rows = clampv(longint'(rows_reg), 2, 16);
		cols = clampv(longint'(cols_reg), 2, 16);
		su = clampv(longint'(su_reg), 1, 4096);
		sv = clampv(longint'(sv_reg), 1, 4096);
		if (ii >= su || jj >= sv) begin
			r.status = 1'b1;
			return r;
		end
		row = ii * (rows - 1) / su;
		prod = jj * (cols - 1);
		seg = prod / sv;
		rem = prod % sv;
		t = (rem << 16) / sv;
		t2 = (t * t) << 16;
		t3 = t * t * t;
		t1 = t << 32;
		one = longint'(1) << 48;
		b[0] = rnd_shift(2 * t3 - 3 * t2 + one, 32);
		b[1] = rnd_shift(-2 * t3 + 3 * t2, 32);
		b[2] = rnd_shift(t3 - 2 * t2 + t1, 32);
		b[3] = rnd_shift(t3 - t2, 32);
		a0 = int'(row * 16 + seg);
		a1 = a0 + 1;
		for (int c = 0; c < 3; c++) begin
			acc = longint'(pt_mem[a0][c]) * b[0] + longint'(pt_mem[a1][c]) * b[1]
				+ longint'(tg_mem[a0][c]) * b[2] + longint'(tg_mem[a1][c]) * b[3];
			v = clampv(rnd_shift(acc, 16), -64'sd2147483648, 64'sd2147483647);
			if (c == 0) r.x = v[31:0];
			else if (c == 1) r.y = v[31:0];
			else r.z = v[31:0];
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		point_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (point_q.size() == 0) begin
				$error("unexpected result x=%h", m_tdata[31:0]);
				fail_cnt++;
			end else begin
				e = point_q.pop_front();
				if (m_tdata[31:0] !== e.x) begin
					$error("point_x exp %h got %h", e.x, m_tdata[31:0]); fail_cnt++;
				end
				if (m_tdata[63:32] !== e.y) begin
					$error("point_y exp %h got %h", e.y, m_tdata[63:32]); fail_cnt++;
				end
				if (m_tdata[95:64] !== e.z) begin
					$error("point_z exp %h got %h", e.z, m_tdata[95:64]); fail_cnt++;
				end
				if (m_tuser !== e.status) begin
					$error("status exp %b got %b", e.status, m_tuser); fail_cnt++;
				end
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_req(op_t op, logic [3:0] r, logic [3:0] c, logic [31:0] x,
		logic [31:0] y, logic [31:0] z, logic [11:0] i, logic [11:0] j);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {j, i, z, y, x, c, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_LOAD_POINT) begin
			pt_mem[{r, c}][0] = x; pt_mem[{r, c}][1] = y; pt_mem[{r, c}][2] = z;
		end else if (op == OP_LOAD_TANGENT) begin
			tg_mem[{r, c}][0] = x; tg_mem[{r, c}][1] = y; tg_mem[{r, c}][2] = z;
		end else if (op == OP_EVALUATE) begin
			point_q.insert(point_q.size(), eval_point(i, j));
		end
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (point_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		case (idx)
			REG_GRID_ROWS: rows_reg = val[4:0];
			REG_GRID_COLS: cols_reg = val[4:0];
			REG_SAMPLES_U: su_reg = val[12:0];
			default: sv_reg = val[12:0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_grid(logic [31:0] r, logic [31:0] c, logic [31:0] u, logic [31:0] v);
		drain();
		apb_write(REG_GRID_ROWS, r);
		apb_write(REG_GRID_COLS, c);
		apb_write(REG_SAMPLES_U, u);
		apb_write(REG_SAMPLES_V, v);
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_fill_stores();
		for (int a = 0; a < 256; a++) begin
			send_req(OP_LOAD_POINT, a[7:4], a[3:0], rnd_coord(), rnd_coord(), rnd_coord(), 0, 0);
			send_req(OP_LOAD_TANGENT, a[7:4], a[3:0], rnd_coord(), rnd_coord(), rnd_coord(),
				12'($urandom), 12'($urandom));
		end
	endtask

	task automatic test_directed();
		send_req(OP_LOAD_POINT, 0, 0, 32'h7fffffff, 32'h80000000, 32'h0, 0, 0);
		send_req(OP_LOAD_POINT, 0, 1, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 0);
		send_req(OP_LOAD_TANGENT, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0);
		send_req(OP_LOAD_TANGENT, 0, 1, 32'h7fffffff, 32'h80000000, 32'hffff0000, 0, 0);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 0);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 17);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 33);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 99, 99);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 100, 0);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 100);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 12'hfff, 12'hfff);
		send_req(op_t'(2'd3), 4'hf, 4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			12'hfff, 12'hfff);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 50, 66);
		set_grid(16, 16, 4096, 4096);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 12'hfff, 12'hfff);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 1);
		set_grid(32'hffffffe0, 32'h21, 32'hffffe001, 32'h1fff);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 0, 4095);
		send_req(OP_EVALUATE, 0, 0, 0, 0, 0, 1, 0);
	endtask

	task automatic test_random(int n, int idle, int stall);
		int op_sel;
		send_idle = idle;
		recv_stall = stall;
		for (int k = 0; k < n; k++) begin
			op_sel = $urandom_range(0, 19);
			if (op_sel < 3)
				send_req(OP_LOAD_POINT, 4'($urandom), 4'($urandom), rnd_coord(), rnd_coord(),
					rnd_coord(), 12'($urandom), 12'($urandom));
			else if (op_sel < 6)
				send_req(OP_LOAD_TANGENT, 4'($urandom), 4'($urandom), rnd_coord(), rnd_coord(),
					rnd_coord(), 12'($urandom), 12'($urandom));
			else if (op_sel < 7)
				send_req(op_t'(2'd3), 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
					12'($urandom), 12'($urandom));
			else if (op_sel < 10)
				send_req(OP_EVALUATE, 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
					12'($urandom), 12'($urandom));
			else
				send_req(OP_EVALUATE, 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
					12'($urandom_range(0, 32'(clampv(longint'(su_reg), 1, 4096) - 1))),
					12'($urandom_range(0, 32'(clampv(longint'(sv_reg), 1, 4096) - 1))));
		end
	endtask

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0; m_tready = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		rows_reg = GRID_ROWS_RST; cols_reg = GRID_COLS_RST;
		su_reg = SAMPLES_U_RST; sv_reg = SAMPLES_V_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_fill_stores();
		test_directed();
		set_grid(4, 4, 100, 100);
		test_random(80, 0, 0);
		set_grid(16, 16, 4096, 4096);
		test_random(80, 66, 0);
		set_grid(2, 2, 1, 1);
		test_random(80, 0, 66);
		set_grid($urandom_range(2, 16), $urandom_range(2, 16), $urandom_range(1, 300),
			$urandom_range(1, 300));
		test_random(80, 26, 26);
		drain();
		if (fail_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/hgpe_pkg.sv
rtl/hgpe_ram.sv
rtl/hgpe_div.sv
rtl/hermite_grid_point_evaluator_core.sv
verif/hermite_grid_point_evaluator_core_tb.sv
